@@ design/projected_segment_crossing_defines.svh @@
// Assertion macros shared by the projected segment crossing design.
`ifndef PROJECTED_SEGMENT_CROSSING_DEFINES_SVH
`define PROJECTED_SEGMENT_CROSSING_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PSC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PSC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);
`else
`define PSC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PSC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

@@ design/psc_pkg.sv @@
`default_nettype none
package psc_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int PROD_W     = 66;
    localparam int DET_W      = 67;
    localparam int NUM_W      = DET_W + FRAC_BITS;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int MARGIN_W   = 15;
    localparam int PARAM_W    = 18;
    localparam int ZD_W       = 33;
    localparam int CMP_W      = DET_W + ZD_W + 2;
    localparam int BOUND_W    = DET_W + FRAC_BITS + 2;
    localparam int NUM_CELLS  = Q_W;
    // Wide operands are split into a signed upper part and an unsigned lower part.
    localparam int SPLIT_W    = 34;
    localparam int HI_W       = DET_W + 1 - SPLIT_W;
    localparam int PART_W     = SPLIT_W + 1 + ZD_W;

    // Data handed from one divider cell to the next.
    typedef struct packed {
        logic                 live;
        logic                 crossing;
        logic                 above;
        logic                 detneg;
        logic [DET_W-1:0]     det;
        logic [NUM_W:0]       rem;
        logic [Q_W-1:0]       quo;
    } cell_data_t;
endpackage
`default_nettype wire

@@ design/psc_div_cell.sv @@
`default_nettype none
`include "projected_segment_crossing_defines.svh"
module psc_div_cell
    import psc_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic [4:0]     bit_index,
    input  wire cell_data_t     din,
    output cell_data_t          dout
);
    cell_data_t       data_reg;
    cell_data_t       data_next;
    logic             live_reg;
    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   limit;

    // One restoring step: compare the remainder against det shifted up.
    always_comb
    begin
        shifted   = {{(NUM_W + 1 - DET_W){1'b0}}, din.det} << bit_index;
        data_next = din;
        if (din.rem >= shifted)
        begin
            data_next.rem = din.rem - shifted;
            data_next.quo = din.quo | (Q_W'(1) << bit_index);
        end
    end

    // The live flag is reset on its own; the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (advance)
        begin
            live_reg <= din.live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        dout      = data_reg;
        dout.live = live_reg;
    end

    assign limit = {{(NUM_W + 1 - DET_W){1'b0}}, data_reg.det} << bit_index;

    `PSC_ASSERT_NEXT(a_cell_hold, clk, rst_n, !advance, $stable(live_reg), "cell live changed while stalled")
    `PSC_ASSERT_NEXT(a_cell_take, clk, rst_n, advance, live_reg == $past(din.live), "cell lost a beat")
    `PSC_ASSERT_IMPL(a_cell_rem, clk, rst_n, !(live_reg && data_reg.crossing) || data_reg.rem < limit, "remainder out of range")
endmodule
`default_nettype wire

@@ design/projected_segment_crossing.sv @@
// Pipeline: an input beat passes through six front-end stages, 17 divider cells and
// the output register before its result is valid.
// Throughput: one beat per cycle; the whole pipeline advances whenever the output
// register is empty or being drained, so the output stall is the only limit.
// Reset: rst_n clears all valid flags and sets margin_reg to 1; payload registers
// are not reset.
`default_nettype none
`include "projected_segment_crossing_defines.svh"
module projected_segment_crossing
    import psc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [MARGIN_W-1:0]        cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [COORD_W-1:0]  first_start_x,
    input  wire logic signed [COORD_W-1:0]  first_start_y,
    input  wire logic signed [COORD_W-1:0]  first_start_z,
    input  wire logic signed [COORD_W-1:0]  first_end_x,
    input  wire logic signed [COORD_W-1:0]  first_end_y,
    input  wire logic signed [COORD_W-1:0]  first_end_z,
    input  wire logic signed [COORD_W-1:0]  second_start_x,
    input  wire logic signed [COORD_W-1:0]  second_start_y,
    input  wire logic signed [COORD_W-1:0]  second_start_z,
    input  wire logic signed [COORD_W-1:0]  second_end_x,
    input  wire logic signed [COORD_W-1:0]  second_end_y,
    input  wire logic signed [COORD_W-1:0]  second_end_z,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            crossing,
    output logic                            first_above,
    output logic signed [PARAM_W-1:0]       signed_param
);
    // The pipeline moves as one unit. It advances when the output register is free
    // or is being emptied in this cycle.
    logic advance;
    logic out_valid_reg;
    logic [MARGIN_W-1:0] margin_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_W'(1);
        end
        else if (cfg_we)
        begin
            margin_reg <= cfg_wdata;
        end
    end

    // Stage 1: coordinate differences.
    logic v1_reg;
    logic signed [DIFF_W-1:0] a1_reg, b1_reg, c1_reg, d1_reg, rx1_reg, ry1_reg;
    logic signed [ZD_W-1:0]   dz1a_reg, dz1b_reg;
    logic signed [COORD_W-1:0] s1z1_reg, s2z1_reg;

    // Stage 2: products for det, n0, n1.
    logic v2_reg;
    logic signed [PROD_W-1:0] ad_reg, bc_reg, drx_reg, bry_reg, ary_reg, crx_reg;
    logic signed [ZD_W-1:0]   dz2a_reg, dz2b_reg;
    logic signed [COORD_W-1:0] s1z2_reg, s2z2_reg;

    // Stage 3: det made positive; n0 and n1 negated with it when det is negative.
    logic v3_reg, detneg3_reg, nz3_reg;
    logic signed [DET_W:0] det3_reg, n03_reg, n13_reg;
    logic signed [ZD_W-1:0]   dz3a_reg, dz3b_reg;
    logic signed [COORD_W-1:0] s1z3_reg, s2z3_reg;

    // Stage 4: partial products. Each wide operand is split into a signed upper
    // half and an unsigned lower half, so no multiplier grows past 35 by 33.
    logic v4_reg, detneg4_reg, nz4_reg;
    logic signed [DET_W:0] det4_reg, n04_reg, n14_reg;
    logic signed [PART_W-1:0] mh4_reg, ml4_reg;
    logic signed [PART_W-1:0] p0h4_reg, p0l4_reg, p1h4_reg, p1l4_reg;
    logic signed [PART_W-1:0] p2h4_reg, p2l4_reg, p3h4_reg, p3l4_reg;

    // Stage 5: margin bounds and the two interpolated heights, scaled by det.
    logic v5_reg, detneg5_reg, nz5_reg;
    logic [DET_W-1:0] det5_reg;
    logic signed [DET_W:0] n05_reg, n15_reg;
    logic signed [BOUND_W-1:0] lowb5_reg, highb5_reg;
    logic signed [CMP_W-1:0] lhs5_reg, rhs5_reg;

    // Stage 6: window test and height compare.
    logic v6_reg, cross6_reg, above6_reg, detneg6_reg;
    logic [DET_W-1:0] det6_reg;
    logic [NUM_W:0]   num6_reg;

    logic signed [DET_W:0] det_c, n0_c, n1_c, n0_abs, n1_abs;
    logic signed [HI_W-1:0] det_hi, n0_hi, n1_hi;
    logic signed [SPLIT_W:0] det_lo, n0_lo, n1_lo;
    logic signed [MARGIN_W:0] margin_s;
    logic signed [BOUND_W-1:0] lowb_c, highb_c, n0s_c, n1s_c;
    logic signed [CMP_W-1:0] lhs_c, rhs_c;
    logic window_c;

    always_comb
    begin
        n0_c   = (DET_W + 1)'(drx_reg) - (DET_W + 1)'(bry_reg);
        n1_c   = (DET_W + 1)'(ary_reg) - (DET_W + 1)'(crx_reg);
        det_c  = (DET_W + 1)'(ad_reg) - (DET_W + 1)'(bc_reg);
        n0_abs = det_c[DET_W] ? -n0_c : n0_c;
        n1_abs = det_c[DET_W] ? -n1_c : n1_c;

        det_hi   = det3_reg[DET_W:SPLIT_W];
        det_lo   = {1'b0, det3_reg[SPLIT_W-1:0]};
        n0_hi    = n03_reg[DET_W:SPLIT_W];
        n0_lo    = {1'b0, n03_reg[SPLIT_W-1:0]};
        n1_hi    = n13_reg[DET_W:SPLIT_W];
        n1_lo    = {1'b0, n13_reg[SPLIT_W-1:0]};
        margin_s = {1'b0, margin_reg};

        // Recombine the halves: upper part shifted up plus lower part.
        lowb_c  = (BOUND_W'(mh4_reg) <<< SPLIT_W) + BOUND_W'(ml4_reg);
        highb_c = (BOUND_W'(det4_reg) <<< FRAC_BITS) - lowb_c;
        lhs_c   = (CMP_W'(p0h4_reg) <<< SPLIT_W) + (CMP_W'(p1h4_reg) <<< SPLIT_W)
                  + CMP_W'(p0l4_reg) + CMP_W'(p1l4_reg);
        rhs_c   = (CMP_W'(p2h4_reg) <<< SPLIT_W) + (CMP_W'(p3h4_reg) <<< SPLIT_W)
                  + CMP_W'(p2l4_reg) + CMP_W'(p3l4_reg);

        n0s_c    = BOUND_W'(n05_reg) <<< FRAC_BITS;
        n1s_c    = BOUND_W'(n15_reg) <<< FRAC_BITS;
        window_c = nz5_reg && (lowb5_reg < n0s_c) && (n0s_c < highb5_reg)
                   && (lowb5_reg < n1s_c) && (n1s_c < highb5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a1_reg   <= DIFF_W'(first_end_x) - DIFF_W'(first_start_x);
            b1_reg   <= DIFF_W'(second_start_x) - DIFF_W'(second_end_x);
            c1_reg   <= DIFF_W'(first_end_y) - DIFF_W'(first_start_y);
            d1_reg   <= DIFF_W'(second_start_y) - DIFF_W'(second_end_y);
            rx1_reg  <= DIFF_W'(second_start_x) - DIFF_W'(first_start_x);
            ry1_reg  <= DIFF_W'(second_start_y) - DIFF_W'(first_start_y);
            dz1a_reg <= ZD_W'(first_end_z) - ZD_W'(first_start_z);
            dz1b_reg <= ZD_W'(second_end_z) - ZD_W'(second_start_z);
            s1z1_reg <= first_start_z;
            s2z1_reg <= second_start_z;

            ad_reg   <= PROD_W'(a1_reg) * PROD_W'(d1_reg);
            bc_reg   <= PROD_W'(b1_reg) * PROD_W'(c1_reg);
            drx_reg  <= PROD_W'(d1_reg) * PROD_W'(rx1_reg);
            bry_reg  <= PROD_W'(b1_reg) * PROD_W'(ry1_reg);
            ary_reg  <= PROD_W'(a1_reg) * PROD_W'(ry1_reg);
            crx_reg  <= PROD_W'(c1_reg) * PROD_W'(rx1_reg);
            dz2a_reg <= dz1a_reg;
            dz2b_reg <= dz1b_reg;
            s1z2_reg <= s1z1_reg;
            s2z2_reg <= s2z1_reg;

            det3_reg    <= det_c[DET_W] ? -det_c : det_c;
            detneg3_reg <= det_c[DET_W];
            nz3_reg     <= (det_c != '0);
            n03_reg     <= n0_abs;
            n13_reg     <= n1_abs;
            dz3a_reg    <= dz2a_reg;
            dz3b_reg    <= dz2b_reg;
            s1z3_reg    <= s1z2_reg;
            s2z3_reg    <= s2z2_reg;

            det4_reg    <= det3_reg;
            detneg4_reg <= detneg3_reg;
            nz4_reg     <= nz3_reg;
            n04_reg     <= n03_reg;
            n14_reg     <= n13_reg;
            mh4_reg     <= PART_W'(det_hi * margin_s);
            ml4_reg     <= PART_W'(det_lo * margin_s);
            p0h4_reg    <= PART_W'(n0_hi * dz3a_reg);
            p0l4_reg    <= PART_W'(n0_lo * dz3a_reg);
            p1h4_reg    <= PART_W'(det_hi * s1z3_reg);
            p1l4_reg    <= PART_W'(det_lo * s1z3_reg);
            p2h4_reg    <= PART_W'(n1_hi * dz3b_reg);
            p2l4_reg    <= PART_W'(n1_lo * dz3b_reg);
            p3h4_reg    <= PART_W'(det_hi * s2z3_reg);
            p3l4_reg    <= PART_W'(det_lo * s2z3_reg);

            det5_reg    <= det4_reg[DET_W-1:0];
            detneg5_reg <= detneg4_reg;
            nz5_reg     <= nz4_reg;
            n05_reg     <= n04_reg;
            n15_reg     <= n14_reg;
            lowb5_reg   <= lowb_c;
            highb5_reg  <= highb_c;
            lhs5_reg    <= lhs_c;
            rhs5_reg    <= rhs_c;

            cross6_reg  <= window_c;
            above6_reg  <= window_c && (rhs5_reg < lhs5_reg);
            detneg6_reg <= detneg5_reg;
            det6_reg    <= det5_reg;
            num6_reg    <= (NUM_W + 1)'(n0s_c);
        end
    end

    // The chain of divider cells: cell k settles quotient bit Q_W-1-k.
    cell_data_t chain [NUM_CELLS+1];

    assign chain[0] = {v6_reg, cross6_reg, above6_reg, detneg6_reg, det6_reg, num6_reg,
                       Q_W'(0)};

    genvar k;
    generate
        for (k = 0; k < NUM_CELLS; k++)
        begin : g_cell
            psc_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .bit_index (5'(Q_W - 1 - k)),
                .din       (chain[k]),
                .dout      (chain[k+1])
            );
        end
    endgenerate

    // Output register fed from the last cell.
    logic                      cross_reg, above_reg;
    logic signed [PARAM_W-1:0] param_reg;
    cell_data_t                tail;
    logic [PARAM_W-1:0]        qext;

    assign tail = chain[NUM_CELLS];
    assign qext = PARAM_W'(tail.quo);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= tail.live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cross_reg <= tail.crossing;
            above_reg <= tail.crossing && tail.above;
            if (!tail.crossing)
            begin
                param_reg <= '0;
            end
            else if (tail.above == tail.detneg)
            begin
                param_reg <= qext;
            end
            else
            begin
                param_reg <= -qext;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign crossing     = cross_reg;
    assign first_above  = above_reg;
    assign signed_param = param_reg;

    `PSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(signed_param), "result dropped while stalled")
    `PSC_ASSERT_IMPL(a_no_cross_zero, clk, rst_n, !out_valid || crossing || (signed_param == '0 && !first_above), "non-crossing result carries data")
    `PSC_ASSERT_IMPL(a_ready_tracks, clk, rst_n, in_ready == (!out_valid || out_ready), "input ready disagrees with output stall")
endmodule
`default_nettype wire
